// ----- design/w2pt_pkg.sv -----
// Package for the waves2 point transform: fixed-point formats, angle constants,
// CORDIC arctangent table, register indexes and shared types.
// No dependencies.
package w2pt_pkg;

   localparam int FRAC_BITS         = 16;
   localparam int CORDIC_STAGES_DEF = 18;
   localparam int DATA_W            = 32;
   localparam int CSR_IDX_W         = 3;
   localparam int NUM_LANES         = 3;

   localparam int ANG_FRAC = 2 * FRAC_BITS;
   localparam int SIN_FRAC = 30;
   localparam int ANG_SH   = ANG_FRAC - SIN_FRAC;

   localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

   function automatic logic [63:0] pi_const(input int sh);
      return (PI_Q61 + (64'd1 << (sh - 1))) >> sh;
   endfunction

   localparam logic [63:0] TWO_PI  = pi_const(60 - ANG_FRAC);
   localparam logic [63:0] PI_VAL  = pi_const(61 - ANG_FRAC);
   localparam logic [63:0] HALF_PI = pi_const(62 - ANG_FRAC);

   // 2^64 mod two pi, by doubling with conditional subtract
   function automatic logic [63:0] pow64_mod(input logic [63:0] m);
      logic [63:0] c;
      c = 64'd1;
      for (int k = 0; k < 64; k++) begin
         c = c << 1;
         if (c >= m) begin
            c = c - m;
         end
      end
      return c;
   endfunction

   localparam logic [63:0] C64     = pow64_mod(TWO_PI);
   localparam logic [63:0] M_MINUS_C64 = TWO_PI - C64;

   localparam int MOD_W     = $clog2(TWO_PI);
   localparam int REM_TOP   = MOD_W - 1;
   localparam int RED_LOW   = 64 - REM_TOP;
   localparam int RED_STEPS = RED_LOW / 2;
   localparam int ANG_W     = MOD_W + 1;
   localparam int Z_W       = ANG_W + 1 - ANG_SH;

   localparam int SQ_STEPS = 32;

   localparam logic signed [31:0] CORDIC_KINV = 32'sh26DD3B6A;

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FREQ_X  = 3'd0,
      REG_FREQ_Y  = 3'd1,
      REG_FREQ_Z  = 3'd2,
      REG_SCALE_X = 3'd3,
      REG_SCALE_Y = 3'd4,
      REG_SCALE_Z = 3'd5,
      REG_WEIGHT  = 3'd6
   } csr_reg_type;

   localparam int NUM_REGS = 7;

   typedef struct packed {
      logic [NUM_LANES-1:0][DATA_W-1:0] coord;
      logic [NUM_LANES-1:0][DATA_W-1:0] acc;
   } side_type;

   function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
      if (v > 49'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -49'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

// ----- design/waves2_point_transform.sv -----
// Waves2 point transform: pipelined integer square root, modulo-two-pi angle
// reduction, CORDIC sine and weighted saturating accumulate, three lanes.
// Depends on w2pt_pkg.
//
// Usage: a beat is taken at each rising edge with start high; busy stays low,
// so a new point may enter every cycle. Each beat carries point_x/y/z and the
// incoming accumulator acc_x/y/z, all signed Q16.16.
// One result beat comes out per input beat, in order: rsp_valid is high for
// one cycle, with rsp_sum_x/y/z valid in that cycle.
// The pipeline runs through the 32-step square root, the 15 two-bit remainder
// steps and the CORDIC stages; throughput is one point per clock.
// The receiver cannot stall; results are presented once and not held.
// The csr port writes register csr_index with csr_wdata when csr_we is high;
// indexes above six are ignored. Write only while the pipeline is empty.
// Synchronous reset empties the pipeline and loads the register defaults:
// freq_x = freq_y = 2.0, scale_x = scale_y = weight = 1.0, others zero.
module waves2_point_transform
   import w2pt_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [DATA_W-1:0]    req_point_x,
   input  logic signed [DATA_W-1:0]    req_point_y,
   input  logic signed [DATA_W-1:0]    req_point_z,
   input  logic signed [DATA_W-1:0]    req_acc_x,
   input  logic signed [DATA_W-1:0]    req_acc_y,
   input  logic signed [DATA_W-1:0]    req_acc_z,
   output logic                        rsp_valid,
   output logic signed [DATA_W-1:0]    rsp_sum_x,
   output logic signed [DATA_W-1:0]    rsp_sum_y,
   output logic signed [DATA_W-1:0]    rsp_sum_z,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [DATA_W-1:0]           csr_wdata
);

   localparam int ST_SSQ  = 2;
   localparam int ST_TERM = ST_SSQ + SQ_STEPS + RED_STEPS + CORDIC_STAGES + 7;
   localparam int ST_WARP = ST_TERM + 1;
   localparam int ST_WGT  = ST_TERM + 2;
   localparam int ST_OUT  = ST_TERM + 3;

   localparam logic [MOD_W-1:0] TWO_PI_W = TWO_PI[MOD_W-1:0];
   localparam logic [MOD_W-1:0] PI_W     = PI_VAL[MOD_W-1:0];
   localparam logic [MOD_W-1:0] C64_W    = C64[MOD_W-1:0];
   localparam logic [MOD_W-1:0] MC64_W   = M_MINUS_C64[MOD_W-1:0];
   localparam logic [MOD_W+1:0] M1 = {2'b00, TWO_PI_W};
   localparam logic [MOD_W+1:0] M2 = {1'b0, TWO_PI_W, 1'b0};
   localparam logic [MOD_W+1:0] M3 = M1 + M2;
   localparam logic signed [ANG_W-1:0] PI_S      = $signed({1'b0, PI_W});
   localparam logic signed [ANG_W-1:0] NEG_PI_S  = -PI_S;
   localparam logic signed [ANG_W-1:0] HALF_S    = $signed({1'b0, HALF_PI[MOD_W-1:0]});
   localparam logic signed [ANG_W-1:0] NEG_HALF_S = -HALF_S;
   localparam logic signed [ANG_W:0]   Z_RND     = (ANG_W+1)'(1) <<< (ANG_SH - 1);
   localparam logic signed [63:0]      SIN_RND   = 64'sd1 <<< (SIN_FRAC - 1);
   localparam logic signed [63:0]      WGT_RND   = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [DATA_W-1:0] ONE_Q    = 32'sd1 <<< FRAC_BITS;

   // ---------------- configuration registers
   logic signed [DATA_W-1:0] cfg_ff [0:NUM_REGS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[REG_FREQ_X]  <= ONE_Q <<< 1;
         cfg_ff[REG_FREQ_Y]  <= ONE_Q <<< 1;
         cfg_ff[REG_FREQ_Z]  <= '0;
         cfg_ff[REG_SCALE_X] <= ONE_Q;
         cfg_ff[REG_SCALE_Y] <= ONE_Q;
         cfg_ff[REG_SCALE_Z] <= '0;
         cfg_ff[REG_WEIGHT]  <= ONE_Q;
      end else if (csr_we) begin
         case (csr_index)
            REG_FREQ_X, REG_FREQ_Y, REG_FREQ_Z, REG_SCALE_X, REG_SCALE_Y,
            REG_SCALE_Z, REG_WEIGHT: begin
               cfg_ff[csr_index] <= $signed(csr_wdata);
            end
            default: begin
            end
         endcase
      end
   end

   logic signed [DATA_W-1:0] scale_lane [0:NUM_LANES-1];
   always_comb begin
      scale_lane[0] = cfg_ff[REG_SCALE_X];
      scale_lane[1] = cfg_ff[REG_SCALE_Y];
      scale_lane[2] = cfg_ff[REG_SCALE_Z];
   end

   // ---------------- valid and side-data delay lines
   logic     vld_ff  [0:ST_OUT];
   side_type side_ff [0:ST_OUT-1];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= ST_OUT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= start & ~busy;
         for (int k = 1; k <= ST_OUT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0].coord <= {req_point_z, req_point_y, req_point_x};
      side_ff[0].acc   <= {req_acc_z, req_acc_y, req_acc_x};
      for (int k = 1; k < ST_OUT; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   // ---------------- angle products and squares
   logic signed [63:0] angx_ff, angy_ff;
   logic [63:0]        sqx_ff, sqy_ff;
   logic [DATA_W-1:0]  mag_x, mag_y;

   always_comb begin
      mag_x = side_ff[0].coord[0][DATA_W-1] ? (~side_ff[0].coord[0] + 32'd1)
                                            : side_ff[0].coord[0];
      mag_y = side_ff[0].coord[1][DATA_W-1] ? (~side_ff[0].coord[1] + 32'd1)
                                            : side_ff[0].coord[1];
   end

   always_ff @(posedge clock) begin
      angx_ff <= $signed(side_ff[0].coord[1]) * cfg_ff[REG_FREQ_X];
      angy_ff <= $signed(side_ff[0].coord[0]) * cfg_ff[REG_FREQ_Y];
      sqx_ff  <= mag_x * mag_x;
      sqy_ff  <= mag_y * mag_y;
   end

   // ---------------- square root, one result bit per stage
   logic [63:0]        sq_s_ff   [0:SQ_STEPS];
   logic [63:0]        sq_r_ff   [0:SQ_STEPS];
   logic signed [63:0] sq_angx_ff [0:SQ_STEPS];
   logic signed [63:0] sq_angy_ff [0:SQ_STEPS];

   always_ff @(posedge clock) begin
      sq_s_ff[0]    <= sqx_ff + sqy_ff;
      sq_r_ff[0]    <= '0;
      sq_angx_ff[0] <= angx_ff;
      sq_angy_ff[0] <= angy_ff;
   end

   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
      localparam logic [63:0] SQ_BIT = 64'd1 << (2 * (SQ_STEPS - 1 - j));
      logic [64:0] trial;
      logic        fit;
      always_comb begin
         trial = {1'b0, sq_r_ff[j]} + {1'b0, SQ_BIT};
         fit   = {1'b0, sq_s_ff[j]} >= trial;
      end
      always_ff @(posedge clock) begin
         sq_s_ff[j+1]    <= fit ? sq_s_ff[j] - trial[63:0] : sq_s_ff[j];
         sq_r_ff[j+1]    <= fit ? (sq_r_ff[j] >> 1) + SQ_BIT : sq_r_ff[j] >> 1;
         sq_angx_ff[j+1] <= sq_angx_ff[j];
         sq_angy_ff[j+1] <= sq_angy_ff[j];
      end
   end

   logic [DATA_W-1:0]  rad_ff;
   logic signed [63:0] rnd_angx_ff, rnd_angy_ff;

   always_ff @(posedge clock) begin
      rad_ff <= (sq_s_ff[SQ_STEPS] > sq_r_ff[SQ_STEPS])
                ? sq_r_ff[SQ_STEPS][DATA_W-1:0] + 32'd1
                : sq_r_ff[SQ_STEPS][DATA_W-1:0];
      rnd_angx_ff <= sq_angx_ff[SQ_STEPS];
      rnd_angy_ff <= sq_angy_ff[SQ_STEPS];
   end

   // ---------------- radius angle and split for the remainder
   logic signed [64:0] angz_prod;
   logic [63:0]        ang_lane [0:NUM_LANES-1];

   always_comb begin
      angz_prod   = $signed({1'b0, rad_ff}) * cfg_ff[REG_FREQ_Z];
      ang_lane[0] = rnd_angx_ff;
      ang_lane[1] = rnd_angy_ff;
      ang_lane[2] = angz_prod[63:0];
   end

   logic [MOD_W-1:0]   red_rem_ff [0:RED_STEPS][0:NUM_LANES-1];
   logic [RED_LOW-1:0] red_lo_ff  [0:RED_STEPS][0:NUM_LANES-1];
   logic               red_neg_ff [0:RED_STEPS][0:NUM_LANES-1];

   always_ff @(posedge clock) begin
      for (int l = 0; l < NUM_LANES; l++) begin
         red_rem_ff[0][l] <= {1'b0, ang_lane[l][63:RED_LOW]};
         red_lo_ff[0][l]  <= ang_lane[l][RED_LOW-1:0];
         red_neg_ff[0][l] <= ang_lane[l][63];
      end
   end

   // ---------------- remainder by two pi, two bits per stage
   for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
      logic [MOD_W+1:0] part [0:NUM_LANES-1];
      logic [MOD_W+1:0] rem_in [0:NUM_LANES-1];
      always_comb begin
         for (int l = 0; l < NUM_LANES; l++) begin
            part[l] = {red_rem_ff[j][l], red_lo_ff[j][l][RED_LOW-1 -: 2]};
            if (part[l] >= M3) begin
               rem_in[l] = part[l] - M3;
            end else if (part[l] >= M2) begin
               rem_in[l] = part[l] - M2;
            end else if (part[l] >= M1) begin
               rem_in[l] = part[l] - M1;
            end else begin
               rem_in[l] = part[l];
            end
         end
      end
      always_ff @(posedge clock) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            red_rem_ff[j+1][l] <= rem_in[l][MOD_W-1:0];
            red_lo_ff[j+1][l]  <= red_lo_ff[j][l] << 2;
            red_neg_ff[j+1][l] <= red_neg_ff[j][l];
         end
      end
   end

   // ---------------- sign fix, wrap to [-pi, pi), fold, scale to 30 bits
   logic [MOD_W-1:0]        sgn_ff  [0:NUM_LANES-1];
   logic signed [ANG_W-1:0] wrap_ff [0:NUM_LANES-1];
   logic signed [ANG_W-1:0] fold_ff [0:NUM_LANES-1];
   logic signed [ANG_W:0]   z_sum   [0:NUM_LANES-1];

   always_ff @(posedge clock) begin
      for (int l = 0; l < NUM_LANES; l++) begin
         if (!red_neg_ff[RED_STEPS][l]) begin
            sgn_ff[l] <= red_rem_ff[RED_STEPS][l];
         end else if (red_rem_ff[RED_STEPS][l] >= C64_W) begin
            sgn_ff[l] <= red_rem_ff[RED_STEPS][l] - C64_W;
         end else begin
            sgn_ff[l] <= red_rem_ff[RED_STEPS][l] + MC64_W;
         end

         if (sgn_ff[l] >= PI_W) begin
            wrap_ff[l] <= $signed({1'b0, sgn_ff[l]}) - $signed({1'b0, TWO_PI_W});
         end else begin
            wrap_ff[l] <= $signed({1'b0, sgn_ff[l]});
         end

         if (wrap_ff[l] > HALF_S) begin
            fold_ff[l] <= PI_S - wrap_ff[l];
         end else if (wrap_ff[l] < NEG_HALF_S) begin
            fold_ff[l] <= NEG_PI_S - wrap_ff[l];
         end else begin
            fold_ff[l] <= wrap_ff[l];
         end
      end
   end

   // ---------------- CORDIC rotation
   logic signed [31:0]    cx_ff [0:CORDIC_STAGES][0:NUM_LANES-1];
   logic signed [31:0]    cy_ff [0:CORDIC_STAGES][0:NUM_LANES-1];
   logic signed [Z_W-1:0] cz_ff [0:CORDIC_STAGES][0:NUM_LANES-1];

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         z_sum[l] = {fold_ff[l][ANG_W-1], fold_ff[l]} + Z_RND;
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < NUM_LANES; l++) begin
         cx_ff[0][l] <= CORDIC_KINV;
         cy_ff[0][l] <= '0;
         cz_ff[0][l] <= z_sum[l][ANG_W:ANG_SH];
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      localparam logic signed [Z_W-1:0] ATAN_I =
         $signed({{(Z_W-32){1'b0}}, ATAN_TAB[i % 32]});
      always_ff @(posedge clock) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            if (cz_ff[i][l] >= 0) begin
               cx_ff[i+1][l] <= cx_ff[i][l] - (cy_ff[i][l] >>> i);
               cy_ff[i+1][l] <= cy_ff[i][l] + (cx_ff[i][l] >>> i);
               cz_ff[i+1][l] <= cz_ff[i][l] - ATAN_I;
            end else begin
               cx_ff[i+1][l] <= cx_ff[i][l] + (cy_ff[i][l] >>> i);
               cy_ff[i+1][l] <= cy_ff[i][l] - (cx_ff[i][l] >>> i);
               cz_ff[i+1][l] <= cz_ff[i][l] + ATAN_I;
            end
         end
      end
   end

   // ---------------- amplitude, warp, weight, accumulate
   logic signed [63:0]       term_ff [0:NUM_LANES-1];
   logic signed [31:0]       warp_ff [0:NUM_LANES-1];
   logic signed [63:0]       wgt_ff  [0:NUM_LANES-1];
   logic signed [31:0]       sum_ff  [0:NUM_LANES-1];
   logic signed [63:0]       term_rnd [0:NUM_LANES-1];
   logic signed [63:0]       wgt_rnd  [0:NUM_LANES-1];
   logic signed [48:0]       warp_in  [0:NUM_LANES-1];
   logic signed [48:0]       sum_in   [0:NUM_LANES-1];

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         term_rnd[l] = term_ff[l] + SIN_RND;
         warp_in[l]  = 49'($signed(side_ff[ST_WARP-1].coord[l]))
                     + 49'($signed(term_rnd[l][63:SIN_FRAC]));
         wgt_rnd[l]  = wgt_ff[l] + WGT_RND;
         sum_in[l]   = 49'($signed(side_ff[ST_WGT].acc[l]))
                     + 49'($signed(wgt_rnd[l][63:FRAC_BITS]));
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < NUM_LANES; l++) begin
         term_ff[l] <= scale_lane[l] * cy_ff[CORDIC_STAGES][l];
         warp_ff[l] <= sat32(warp_in[l]);
         wgt_ff[l]  <= cfg_ff[REG_WEIGHT] * warp_ff[l];
         sum_ff[l]  <= sat32(sum_in[l]);
      end
   end

   assign rsp_valid = vld_ff[ST_OUT];
   assign rsp_sum_x = sum_ff[0];
   assign rsp_sum_y = sum_ff[1];
   assign rsp_sum_z = sum_ff[2];

endmodule
